// ===== rtl/core/seam_carving_min_seam_defines.svh =====
// Assertion macros for the minimum-seam block.
`ifndef SEAM_CARVING_MIN_SEAM_DEFINES_SVH
`define SEAM_CARVING_MIN_SEAM_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define SCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seam block check failed");
// Next-cycle implication, checked outside reset.
`define SCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seam block check failed");
`endif

// ===== rtl/core/scm_pkg.sv =====
// Shared types and constants for the minimum-seam block.
`default_nettype none
package scm_pkg;
    localparam int DEF_MAX_WIDTH   = 512;
    localparam int DEF_MAX_HEIGHT  = 512;
    localparam int DEF_ENERGY_BITS = 16;
    localparam int CUM_W           = 25;
    localparam int IN_E_W          = 16;
    localparam int CFG_W           = 10;
    localparam int COORD_W         = 9;
    localparam logic [CUM_W-1:0] CUM_MAX = '1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC} state_t;

    typedef enum logic {CFG_WIDTH = 1'b0, CFG_HEIGHT = 1'b1} cfg_idx_t;

    localparam logic signed [1:0] DIR_UP    = 2'sb00;
    localparam logic signed [1:0] DIR_LEFT  = 2'sb11;
    localparam logic signed [1:0] DIR_RIGHT = 2'sb01;
endpackage
`default_nettype wire

// ===== rtl/core/scm_line_buf.sv =====
// Row-above line buffer of cumulative energies: one write, two registered reads.
`default_nettype none
module scm_line_buf
    import scm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
)(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [CUM_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [CUM_W-1:0] rdata_a,
    output logic      [CUM_W-1:0] rdata_b
);
    logic [CUM_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two read ports, data registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/scm_dir_store.sv =====
// Per-pixel predecessor direction memory, one write and one registered read.
`default_nettype none
module scm_dir_store
    import scm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
)(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic signed [1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic signed [1:0]      rdata
);
    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/seam_carving_min_seam.sv =====
// A beat accepted in IDLE is captured and its memories read; EXEC then writes its result
// to the output register, stalling while that register is full. New beats wait for IDLE.
// The output register holds a result while the next beat is taken and read.
// Reset: asynchronous active-low; frame size 512x512, raster position at the
// origin, no seam ready. Line buffer and direction memory are not cleared.
`default_nettype none
`include "seam_carving_min_seam_defines.svh"
module seam_carving_min_seam
    import scm_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int ENERGY_BITS = DEF_ENERGY_BITS
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [IN_E_W-1:0]  pixel_energy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CUM_W-1:0]        cum_energy,
    output logic signed [1:0]       direction,
    output logic [COORD_W-1:0]      seam_x,
    output logic [COORD_W-1:0]      seam_y,
    output logic                    frame_done,
    output logic                    seam_last,
    output logic                    trace_error,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int DAW  = XW + YW;
    localparam int DDEP = (1 << XW) * MAX_HEIGHT;
    localparam int E_USE = (ENERGY_BITS < IN_E_W) ? ENERGY_BITS : IN_E_W;
    localparam logic [IN_E_W-1:0] EMASK = IN_E_W'((33'h1 << E_USE) - 33'h1);

    // configuration and frame state
    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [XW-1:0]    col_reg, col_next;
    logic [YW-1:0]    row_reg, row_next;
    logic [CUM_W-1:0] lhold_reg, lhold_next;
    logic [CUM_W-1:0] bbot_reg, bbot_next;
    logic [XW-1:0]    tcol_reg, tcol_next;
    logic [YW-1:0]    trow_reg, trow_next;
    logic             ready_reg, ready_next;
    state_t           state_reg, state_next;

    // captured beat
    logic              req_reg;
    logic [IN_E_W-1:0] e_reg;
    logic [XW-1:0]     x_reg;
    logic [YW-1:0]     y_reg;
    logic              rst_frame_reg;

    // output register
    logic              ov_reg, ov_next;
    logic [CUM_W-1:0]  cum_reg, cum_next;
    logic signed [1:0] dir_reg, dir_next;
    logic [COORD_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic              fd_reg, fd_next, sl_reg, sl_next, te_reg, te_next;

    // effective frame size
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    always_comb
    begin
        if (fw_reg == '0)                      w_eff = WW'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else                                   w_eff = WW'(fw_reg);
        if (fh_reg == '0)                       h_eff = HW'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
        else                                    h_eff = HW'(fh_reg);
    end

    // accept-side address generation
    logic          in_acc;
    logic          acc_restart;
    logic [XW-1:0] acc_x, tc_clamp;
    logic [YW-1:0] acc_y;
    always_comb
    begin
        in_acc      = in_valid && in_ready;
        tc_clamp    = (WW'(tcol_reg) < w_eff) ? tcol_reg : XW'(w_eff - WW'(1));
        acc_restart = ready_reg || (WW'(col_reg) >= w_eff) || (HW'(row_reg) >= h_eff);
        if (req_type)
        begin
            acc_x = tc_clamp;
            acc_y = trow_reg;
        end
        else
        begin
            acc_x = acc_restart ? '0 : col_reg;
            acc_y = acc_restart ? '0 : row_reg;
        end
    end

    // memories
    logic              mem_we;
    logic [CUM_W-1:0]  lb_a, lb_b;
    logic signed [1:0] ds_q;
    logic [CUM_W-1:0]  px_cum;
    logic signed [1:0] px_dir;

    scm_line_buf #(.DEPTH(MAX_WIDTH), .AW(XW)) u_lbuf (
        .clk     (clk),
        .we      (mem_we && !req_reg),
        .waddr   (x_reg),
        .wdata   (px_cum),
        .re      (in_acc && !req_type),
        .raddr_a (acc_x),
        .raddr_b (acc_x + XW'(1)),
        .rdata_a (lb_a),
        .rdata_b (lb_b)
    );

    scm_dir_store #(.DEPTH(DDEP), .AW(DAW)) u_dirs (
        .clk   (clk),
        .we    (mem_we && !req_reg),
        .waddr ({y_reg, x_reg}),
        .wdata (px_dir),
        .re    (in_acc && req_type),
        .raddr ({acc_y, acc_x}),
        .rdata (ds_q)
    );

    // pixel datapath: best of three above, saturated sum
    logic [CUM_W-1:0] lhold_eff, best;
    logic [CUM_W:0]   sum;
    logic [WW-1:0]    x_p1;
    always_comb
    begin
        lhold_eff = rst_frame_reg ? '0 : lhold_reg;
        x_p1      = WW'(x_reg) + WW'(1);
        best      = '0;
        px_dir    = DIR_UP;
        if (y_reg != '0)
        begin
            best = lb_a;
            if ((x_reg != '0) && (lhold_eff < best))
            begin
                best   = lhold_eff;
                px_dir = DIR_LEFT;
            end
            if ((x_p1 < w_eff) && (lb_b < best))
            begin
                best   = lb_b;
                px_dir = DIR_RIGHT;
            end
        end
        sum    = (CUM_W + 1)'(e_reg & EMASK) + {1'b0, best};
        px_cum = sum[CUM_W] ? CUM_MAX : sum[CUM_W-1:0];
    end

    // trace step: next column
    logic [XW:0]   nx;
    logic [XW-1:0] tr_next_col;
    always_comb
    begin
        nx = {1'b0, x_reg} + {{(XW-1){ds_q[1]}}, ds_q};
        if (nx[XW] || ((WW)'(nx[XW-1:0]) >= w_eff))
            tr_next_col = x_reg;
        else
            tr_next_col = nx[XW-1:0];
    end

    // control: state, frame registers, output register
    logic exec_go;
    logic cfg_hit;
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        lhold_next  = lhold_reg;
        bbot_next   = bbot_reg;
        tcol_next   = tcol_reg;
        trow_next   = trow_reg;
        ready_next  = ready_reg;
        ov_next     = ov_reg && !out_ready;
        cum_next    = cum_reg;
        dir_next    = dir_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        fd_next     = fd_reg;
        sl_next     = sl_reg;
        te_next     = te_reg;
        in_ready    = (state_reg == S_IDLE);
        cfg_ready   = 1'b1;
        cfg_hit     = cfg_valid;
        exec_go     = (state_reg == S_EXEC) && (!ov_reg || out_ready);
        mem_we      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                    ov_next    = 1'b1;
                    cum_next   = '0;
                    dir_next   = DIR_UP;
                    sx_next    = '0;
                    sy_next    = '0;
                    fd_next    = 1'b0;
                    sl_next    = 1'b0;
                    te_next    = 1'b0;
                    if (req_reg)
                    begin
                        // seam trace
                        if (!ready_reg)
                        begin
                            te_next = 1'b1;
                        end
                        else
                        begin
                            sx_next = COORD_W'(x_reg);
                            sy_next = COORD_W'(y_reg);
                            if ((y_reg == '0) || (HW'(y_reg) >= h_eff))
                            begin
                                sl_next    = 1'b1;
                                ready_next = 1'b0;
                            end
                            else
                            begin
                                tcol_next = tr_next_col;
                                trow_next = y_reg - YW'(1);
                            end
                        end
                    end
                    else
                    begin
                        // pixel update
                        mem_we     = 1'b1;
                        cum_next   = px_cum;
                        dir_next   = px_dir;
                        lhold_next = lb_a;
                        ready_next = 1'b0;
                        bbot_next  = rst_frame_reg ? CUM_MAX : bbot_reg;
                        if ((HW'(y_reg) + HW'(1)) == h_eff)
                        begin
                            if ((x_reg == '0) || (px_cum < bbot_next))
                            begin
                                bbot_next = px_cum;
                                tcol_next = x_reg;
                            end
                        end
                        if (x_p1 < w_eff)
                        begin
                            col_next = x_reg + XW'(1);
                            row_next = y_reg;
                        end
                        else
                        begin
                            col_next   = '0;
                            lhold_next = '0;
                            if ((HW'(y_reg) + HW'(1)) < h_eff)
                            begin
                                row_next = y_reg + YW'(1);
                            end
                            else
                            begin
                                row_next   = '0;
                                trow_next  = YW'(h_eff - HW'(1));
                                ready_next = 1'b1;
                                sx_next    = COORD_W'(tcol_next);
                                sy_next    = COORD_W'(trow_next);
                                fd_next    = 1'b1;
                                bbot_next  = CUM_MAX;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the frame
        if (cfg_hit)
        begin
            col_next   = '0;
            row_next   = '0;
            lhold_next = '0;
            bbot_next  = CUM_MAX;
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fw_reg    <= CFG_W'(512);
            fh_reg    <= CFG_W'(512);
            col_reg   <= '0;
            row_reg   <= '0;
            lhold_reg <= '0;
            bbot_reg  <= CUM_MAX;
            tcol_reg  <= '0;
            trow_reg  <= '0;
            ready_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            lhold_reg <= lhold_next;
            bbot_reg  <= bbot_next;
            tcol_reg  <= tcol_next;
            trow_reg  <= trow_next;
            ready_reg <= ready_next;
            ov_reg    <= ov_next;
            if (cfg_hit)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:  fw_reg <= cfg_data;
                    CFG_HEIGHT: fh_reg <= cfg_data;
                    default:    fw_reg <= fw_reg;
                endcase
            end
        end
    end

    // beat capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg       <= req_type;
            e_reg         <= pixel_energy;
            x_reg         <= acc_x;
            y_reg         <= acc_y;
            rst_frame_reg <= acc_restart;
        end
        cum_reg <= cum_next;
        dir_reg <= dir_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        fd_reg  <= fd_next;
        sl_reg  <= sl_next;
        te_reg  <= te_next;
    end

    assign out_valid   = ov_reg;
    assign cum_energy  = cum_reg;
    assign direction   = dir_reg;
    assign seam_x      = sx_reg;
    assign seam_y      = sy_reg;
    assign frame_done  = fd_reg;
    assign seam_last   = sl_reg;
    assign trace_error = te_reg;

    // checks
    `SCM_ASSERT_NEXT(a_acc_exec, in_valid && in_ready, state_reg == S_EXEC)
    `SCM_ASSERT_NOW(a_err_clean, out_valid && trace_error, !frame_done && !seam_last)
    `SCM_ASSERT_NOW(a_done_rdy, out_valid && frame_done && !cfg_valid, ready_reg)
endmodule
`default_nettype wire

// ===== verif/seam_carving_min_seam_tb.sv =====
// Self-checking testbench for the minimum-energy vertical seam block.
`default_nettype none
module seam_carving_min_seam_tb;
    import scm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 512;
    localparam int MAXH = 512;

    typedef struct packed {
        logic [CUM_W-1:0]   cum;
        logic signed [1:0]  dir;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic               done;
        logic               last;
        logic               err;
    } seam_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic [IN_E_W-1:0]  pixel_energy = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CUM_W-1:0]   cum_energy;
    logic signed [1:0]  direction;
    logic [COORD_W-1:0] seam_x;
    logic [COORD_W-1:0] seam_y;
    logic               frame_done;
    logic               seam_last;
    logic               trace_error;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // Predictor state
    logic [CUM_W-1:0]   line_cum [0:MAXW-1];
    logic signed [1:0]  dir_mem [0:MAXW*MAXH-1];
    int unsigned        cfg_w, cfg_h;
    int unsigned        col_pos, row_pos, left_hold, bottom_best;
    int unsigned        seam_col, seam_row;
    bit                 seam_ready;

    seam_result_t       expected_q[$];
    int                 fail_count = 0;
    int                 beats_sent = 0;
    bit                 idle_en = 1'b1;
    int                 stall_left = 0;

    seam_carving_min_seam dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pixel_energy(pixel_energy),
        .out_valid(out_valid), .out_ready(out_ready),
        .cum_energy(cum_energy), .direction(direction),
        .seam_x(seam_x), .seam_y(seam_y),
        .frame_done(frame_done), .seam_last(seam_last), .trace_error(trace_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned eff_w();
        return (cfg_w == 0) ? 1 : (cfg_w > MAXW ? MAXW : cfg_w);
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_h == 0) ? 1 : (cfg_h > MAXH ? MAXH : cfg_h);
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        left_hold = 0;
        bottom_best = CUM_MAX;
        seam_ready = 1'b0;
    endfunction

    // Work out the result of one beat and advance the seam search state
    function automatic seam_result_t predict_seam_step(bit is_trace, logic [15:0] e);
        seam_result_t r;
        int unsigned w, h, x, y, c, best, cum;
        int nxt;
        logic signed [1:0] d;
        r = '0;
        w = eff_w();
        h = eff_h();
        if (is_trace)
        begin
            if (!seam_ready)
            begin
                r.err = 1'b1;
                return r;
            end
            c = (seam_col < w) ? seam_col : w - 1;
            r.sx = COORD_W'(c);
            r.sy = COORD_W'(seam_row);
            if (seam_row == 0 || seam_row >= h)
            begin
                r.last = 1'b1;
                seam_ready = 1'b0;
                return r;
            end
            nxt = int'(c) + int'(dir_mem[seam_row*MAXW + c]);
            if (nxt < 0 || nxt >= int'(w))
                nxt = c;
            seam_col = nxt;
            seam_row = seam_row - 1;
            return r;
        end
        if (seam_ready)
            restart_frame();
        if (col_pos >= w || row_pos >= h)
            restart_frame();
        x = col_pos;
        y = row_pos;
        d = DIR_UP;
        best = 0;
        if (y != 0)
        begin
            best = line_cum[x];
            if (x > 0 && left_hold < best)
            begin
                best = left_hold;
                d = DIR_LEFT;
            end
            if (x + 1 < w && line_cum[x+1] < best)
            begin
                best = line_cum[x+1];
                d = DIR_RIGHT;
            end
        end
        cum = e + best;
        if (cum > CUM_MAX)
            cum = CUM_MAX;
        left_hold = line_cum[x];
        line_cum[x] = CUM_W'(cum);
        dir_mem[y*MAXW + x] = d;
        r.cum = CUM_W'(cum);
        r.dir = d;
        if (y + 1 == h && (x == 0 || cum < bottom_best))
        begin
            bottom_best = cum;
            seam_col = x;
        end
        if (x + 1 < w)
            col_pos = x + 1;
        else
        begin
            col_pos = 0;
            left_hold = 0;
            if (y + 1 < h)
                row_pos = y + 1;
            else
            begin
                row_pos = 0;
                seam_row = h - 1;
                seam_ready = 1'b1;
                r.sx = COORD_W'(seam_col);
                r.sy = COORD_W'(seam_row);
                r.done = 1'b1;
                bottom_best = CUM_MAX;
            end
        end
        return r;
    endfunction

    // Result receiver with random backpressure bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation; values are stable mid-cycle
    always @(negedge clk)
    begin
        seam_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with no expectation pending");
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (cum_energy !== exp_r.cum)
                begin
                    $error("cum_energy exp %0d got %0d", exp_r.cum, cum_energy);
                    fail_count++;
                end
                if (direction !== exp_r.dir)
                begin
                    $error("direction exp %0d got %0d", exp_r.dir, direction);
                    fail_count++;
                end
                if (seam_x !== exp_r.sx)
                begin
                    $error("seam_x exp %0d got %0d", exp_r.sx, seam_x);
                    fail_count++;
                end
                if (seam_y !== exp_r.sy)
                begin
                    $error("seam_y exp %0d got %0d", exp_r.sy, seam_y);
                    fail_count++;
                end
                if (frame_done !== exp_r.done)
                begin
                    $error("frame_done exp %0b got %0b", exp_r.done, frame_done);
                    fail_count++;
                end
                if (seam_last !== exp_r.last)
                begin
                    $error("seam_last exp %0b got %0b", exp_r.last, seam_last);
                    fail_count++;
                end
                if (trace_error !== exp_r.err)
                begin
                    $error("trace_error exp %0b got %0b", exp_r.err, trace_error);
                    fail_count++;
                end
            end
        end
    end

    // Send one input beat; valid stays up if the next beat follows directly
    task automatic send_beat(input bit is_trace, input logic [15:0] e);
        bit rdy;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= is_trace;
        pixel_energy <= e;
        expected_q.push_back(predict_seam_step(is_trace, e));
        beats_sent++;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    task automatic send_pixel(input logic [15:0] e);
        send_beat(1'b0, e);
    endtask

    task automatic send_trace();
        send_beat(1'b1, 16'($urandom));
    endtask

    // Wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        bit rdy;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH)
            cfg_w = val;
        else
            cfg_h = val;
        restart_frame();
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_HEIGHT, CFG_W'(h));
    endtask

    task automatic random_frame(input int unsigned n, input bit tie_heavy);
        repeat (n)
            send_pixel(tie_heavy ? 16'($urandom_range(0, 3)) : 16'($urandom));
    endtask

    // A refused trace out of reset, then a small frame with ties, extremes and a full seam walk
    task automatic test_directed();
        send_trace();
        set_size(3, 3);
        send_pixel(16'd1);
        send_pixel(16'd9);
        send_pixel(16'd1);
        send_pixel(16'd0);
        send_pixel(16'd0);
        send_pixel(16'hFFFF);
        send_pixel(16'd5);
        send_pixel(16'd5);
        send_pixel(16'd5);
        repeat (4) send_trace();
        // pixel in the middle of a trace abandons the seam
        random_frame(9, 1'b1);
        send_trace();
        send_pixel(16'hFFFF);
        send_trace();
    endtask

    // Out-of-range and extreme register values
    task automatic test_size_extremes();
        set_size(0, 1023);
        random_frame(MAXH, 1'b0);
        send_trace();
        send_trace();
        // oversized width: a long partial row, then refused traces
        set_size(1023, 0);
        random_frame(200, 1'b0);
        send_trace();
        send_trace();
        // register write in the middle of a frame restarts it
        set_size(4, 2);
        random_frame(5, 1'b1);
        write_reg(CFG_HEIGHT, 3);
        random_frame(12, 1'b1);
        repeat (4) send_trace();
    endtask

    // Mostly complete frames followed by seam walks, with noise and broken sequences
    task automatic test_random(input int target);
        int unsigned w, h, k;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 2) == 0)
                set_size($urandom_range(1, 10), $urandom_range(1, 8));
            w = eff_w();
            h = eff_h();
            k = $urandom_range(0, 9);
            if (k < 7)
            begin
                random_frame(w*h, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, h + 1)) send_trace();
            end
            else if (k < 9)
            begin
                random_frame($urandom_range(1, w*h), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2)) send_trace();
            end
            else
                repeat ($urandom_range(1, 4)) send_trace();
        end
    endtask

    initial
    begin
        cfg_w = 512;
        cfg_h = 512;
        seam_col = 0;
        seam_row = 0;
        restart_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_size_extremes();
        test_random(beats_sent + 110);
        idle_en = 1'b0;
        test_random(beats_sent + 30);
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== seam_carving_min_seam.f =====
+incdir+rtl/core
rtl/core/scm_pkg.sv
rtl/core/scm_line_buf.sv
rtl/core/scm_dir_store.sv
rtl/core/seam_carving_min_seam.sv
verif/seam_carving_min_seam_tb.sv
